// File: rtl/lrgd_pkg.sv
// ----------------------------------------------------------------------------
// lrgd_pkg
// Shared types, constants and helpers of the linear regression trainer.
// ----------------------------------------------------------------------------
package lrgd_pkg;

   localparam int MAX_SAMPLES = 256;
   localparam int ADDR_W      = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
   localparam int COUNT_W     = $clog2(MAX_SAMPLES + 1);
   localparam int DATA_W      = 32;
   localparam int ACC_W       = 64;
   localparam int Q_FRAC      = 16;
   localparam int LR_W        = 16;
   localparam int EPOCH_W     = 16;
   localparam int PROD_W      = LR_W + DATA_W + 1;
   localparam int CSR_ADDR_W  = 4;
   localparam int DIV_CNT_W   = $clog2(ACC_W);

   localparam logic [LR_W-1:0]    LEARN_RATE_RESET  = 16'd66;
   localparam logic [EPOCH_W-1:0] EPOCH_COUNT_RESET = 16'd2000;

   typedef enum logic [1:0] {
      REG_START_WEIGHT = 2'd0,
      REG_START_BIAS   = 2'd1,
      REG_LEARN_RATE   = 2'd2,
      REG_EPOCH_COUNT  = 2'd3
   } csr_reg_type;

   typedef enum logic {
      PASS_COST = 1'b0,
      PASS_GRAD = 1'b1
   } pass_mode_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_COST_RUN,
      ST_COST_DIV,
      ST_GRAD_RUN,
      ST_DIV_W,
      ST_DIV_B,
      ST_UPD_MUL,
      ST_UPD_APPLY,
      ST_DONE
   } trainer_state_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] sample_in_x;
      logic signed [DATA_W-1:0] sample_in_y;
      logic                     last_sample;
   } req_data_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] trained_weight;
      logic signed [DATA_W-1:0] trained_bias;
      logic [DATA_W-1:0]        initial_cost;
      logic [DATA_W-1:0]        final_cost;
      logic                     samples_dropped;
   } rsp_data_type;

   typedef struct packed {
      logic                    done;
      logic [ACC_W-1:0]        err_sum;
      logic signed [ACC_W-1:0] grad_w_sum;
      logic signed [ACC_W-1:0] grad_b_sum;
   } pass_status_type;

   function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
      logic signed [ACC_W-1:0] hi;
      logic signed [ACC_W-1:0] lo;
      hi = ACC_W'(64'sh0000_0000_7FFF_FFFF);
      lo = ACC_W'(-64'sh0000_0000_8000_0000);
      if (v > hi) begin
         sat32 = {1'b0, {(DATA_W-1){1'b1}}};
      end else if (v < lo) begin
         sat32 = {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
         sat32 = v[DATA_W-1:0];
      end
   endfunction

endpackage

// File: rtl/linear_regression_gd_trainer.sv
// ----------------------------------------------------------------------------
// linear_regression_gd_trainer
// A sample without last flag is only put into the store, unless it is full; a
//   last sample is stored likewise and starts a training run over the N stored
//   samples for E epochs.
// Throughput: one sample per cycle while loading; busy holds off transactions
//   while a training run walks the sample store, one entry per cycle.
// Reset: synchronous, clears the control state and restores register defaults.
// The result is shown for one cycle on rsp_valid; the receiver cannot stall.
// ----------------------------------------------------------------------------
module linear_regression_gd_trainer (
   input  logic                                   clock,
   input  logic                                   reset,
   // sample channel
   input  logic                                   start,
   output logic                                   busy,
   input  lrgd_pkg::req_data_type                 req_data,
   // result channel
   output logic                                   rsp_valid,
   output lrgd_pkg::rsp_data_type                 rsp_data,
   // register port
   input  logic                                   psel,
   input  logic                                   penable,
   input  logic                                   pwrite,
   input  logic [lrgd_pkg::CSR_ADDR_W-1:0]        paddr,
   input  logic [lrgd_pkg::DATA_W-1:0]            pwdata,
   output logic [lrgd_pkg::DATA_W-1:0]            prdata,
   output logic                                   pready
);

   // ---------------------------------------------------------------- registers
   logic signed [lrgd_pkg::DATA_W-1:0] start_weight_ff, start_bias_ff;
   logic [lrgd_pkg::LR_W-1:0]          learn_rate_ff;
   logic [lrgd_pkg::EPOCH_W-1:0]       epoch_count_ff;
   logic                               csr_write;
   lrgd_pkg::csr_reg_type              csr_sel;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_sel   = lrgd_pkg::csr_reg_type'(paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         start_weight_ff <= '0;
         start_bias_ff   <= '0;
         learn_rate_ff   <= lrgd_pkg::LEARN_RATE_RESET;
         epoch_count_ff  <= lrgd_pkg::EPOCH_COUNT_RESET;
      end else if (csr_write) begin
         case (csr_sel)
            lrgd_pkg::REG_START_WEIGHT: start_weight_ff <= pwdata;
            lrgd_pkg::REG_START_BIAS:   start_bias_ff   <= pwdata;
            lrgd_pkg::REG_LEARN_RATE:   learn_rate_ff   <= pwdata[lrgd_pkg::LR_W-1:0];
            lrgd_pkg::REG_EPOCH_COUNT:  epoch_count_ff  <= pwdata[lrgd_pkg::EPOCH_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_sel)
         lrgd_pkg::REG_START_WEIGHT: prdata = start_weight_ff;
         lrgd_pkg::REG_START_BIAS:   prdata = start_bias_ff;
         lrgd_pkg::REG_LEARN_RATE:   prdata = lrgd_pkg::DATA_W'(learn_rate_ff);
         lrgd_pkg::REG_EPOCH_COUNT:  prdata = lrgd_pkg::DATA_W'(epoch_count_ff);
         default:                    prdata = '0;
      endcase
   end

   // ------------------------------------------------------------ sample store
   logic                               accept;
   logic                               store_full;
   logic                               store_wr;
   logic                               rd_en;
   logic [lrgd_pkg::ADDR_W-1:0]        rd_addr;
   logic signed [lrgd_pkg::DATA_W-1:0] rd_x, rd_y;
   logic [lrgd_pkg::COUNT_W-1:0]       count_ff, count_in;
   logic                               overflow_ff, overflow_in;

   assign accept     = start && !busy;
   assign store_full = (count_ff == lrgd_pkg::COUNT_W'(lrgd_pkg::MAX_SAMPLES));
   assign store_wr   = accept && !store_full;

   lrgd_ram #(.WIDTH(lrgd_pkg::DATA_W), .DEPTH(lrgd_pkg::MAX_SAMPLES)) u_store_x (
      .clock   (clock),
      .wr_en   (store_wr),
      .wr_addr (count_ff[lrgd_pkg::ADDR_W-1:0]),
      .wr_data (req_data.sample_in_x),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_x)
   );

   lrgd_ram #(.WIDTH(lrgd_pkg::DATA_W), .DEPTH(lrgd_pkg::MAX_SAMPLES)) u_store_y (
      .clock   (clock),
      .wr_en   (store_wr),
      .wr_addr (count_ff[lrgd_pkg::ADDR_W-1:0]),
      .wr_data (req_data.sample_in_y),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_y)
   );

   // ---------------------------------------------------- sweep and divider
   logic                               pass_start;
   lrgd_pkg::pass_mode_type            pass_mode;
   lrgd_pkg::pass_status_type          pass_st;
   logic signed [lrgd_pkg::DATA_W-1:0] weight_ff, weight_in, bias_ff, bias_in;

   // count_in already includes the last sample when the first sweep starts
   lrgd_pass u_pass (
      .clock   (clock),
      .reset   (reset),
      .start   (pass_start),
      .mode    (pass_mode),
      .count   (count_in),
      .weight  (weight_ff),
      .bias    (bias_ff),
      .rd_x    (rd_x),
      .rd_y    (rd_y),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .status  (pass_st)
   );

   logic                          div_start;
   logic [lrgd_pkg::ACC_W-1:0]    div_dividend;
   logic                          div_done;
   logic [lrgd_pkg::ACC_W-1:0]    div_q;
   logic [lrgd_pkg::ACC_W-1:0]    quot;      // zero for an empty store
   logic signed [lrgd_pkg::ACC_W-1:0] quot_signed;
   logic [lrgd_pkg::DATA_W-1:0]   quot_cost;

   lrgd_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (count_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   // ------------------------------------------------------------- sequencer
   lrgd_pkg::trainer_state_type        state_ff, state_in;
   logic                               final_ff, final_in;
   logic                               neg_ff, neg_in;
   logic [lrgd_pkg::EPOCH_W-1:0]       epoch_ff, epoch_in;
   logic signed [lrgd_pkg::DATA_W-1:0] avg_w_ff, avg_w_in, avg_b_ff, avg_b_in;
   logic signed [lrgd_pkg::PROD_W-1:0] prod_w_ff, prod_b_ff;
   logic [lrgd_pkg::DATA_W-1:0]        cost0_ff, cost0_in, cost1_ff, cost1_in;
   logic                               dropped_ff, dropped_in;
   logic signed [lrgd_pkg::ACC_W-1:0]  gw, gb;
   logic signed [lrgd_pkg::ACC_W-1:0]  w_next, b_next;

   assign quot        = (count_ff == '0) ? '0 : div_q;
   assign quot_signed = neg_ff ? -$signed(quot) : $signed(quot);
   assign quot_cost   = (quot[lrgd_pkg::ACC_W-1:lrgd_pkg::DATA_W] != '0)
                        ? '1 : quot[lrgd_pkg::DATA_W-1:0];
   assign gw          = pass_st.grad_w_sum;
   assign gb          = pass_st.grad_b_sum;

   // w - floor(lr*avg / 2^16), saturated
   assign w_next = lrgd_pkg::ACC_W'(weight_ff)
                   - lrgd_pkg::ACC_W'(prod_w_ff >>> lrgd_pkg::Q_FRAC);
   assign b_next = lrgd_pkg::ACC_W'(bias_ff)
                   - lrgd_pkg::ACC_W'(prod_b_ff >>> lrgd_pkg::Q_FRAC);

   always_comb begin
      state_in     = state_ff;
      final_in     = final_ff;
      neg_in       = neg_ff;
      epoch_in     = epoch_ff;
      weight_in    = weight_ff;
      bias_in      = bias_ff;
      avg_w_in     = avg_w_ff;
      avg_b_in     = avg_b_ff;
      cost0_in     = cost0_ff;
      cost1_in     = cost1_ff;
      dropped_in   = dropped_ff;
      count_in     = count_ff;
      overflow_in  = overflow_ff;
      pass_start   = 1'b0;
      pass_mode    = lrgd_pkg::PASS_COST;
      div_start    = 1'b0;
      div_dividend = pass_st.err_sum;
      case (state_ff)
         lrgd_pkg::ST_IDLE: begin
            if (accept) begin
               if (store_full) begin
                  overflow_in = 1'b1;
               end else begin
                  count_in = count_ff + 1'b1;
               end
               if (req_data.last_sample) begin
                  dropped_in = overflow_ff || store_full;
                  weight_in  = start_weight_ff;
                  bias_in    = start_bias_ff;
                  final_in   = 1'b0;
                  epoch_in   = '0;
                  pass_start = 1'b1;
                  state_in   = lrgd_pkg::ST_COST_RUN;
               end
            end
         end
         lrgd_pkg::ST_COST_RUN: begin
            if (pass_st.done) begin
               div_start = 1'b1;
               neg_in    = 1'b0;
               state_in  = lrgd_pkg::ST_COST_DIV;
            end
         end
         lrgd_pkg::ST_COST_DIV: begin
            if (div_done) begin
               if (final_ff) begin
                  cost1_in = quot_cost;
                  state_in = lrgd_pkg::ST_DONE;
               end else begin
                  cost0_in   = quot_cost;
                  pass_start = 1'b1;
                  if (epoch_count_ff == '0) begin
                     final_in = 1'b1;
                     state_in = lrgd_pkg::ST_COST_RUN;
                  end else begin
                     pass_mode = lrgd_pkg::PASS_GRAD;
                     state_in  = lrgd_pkg::ST_GRAD_RUN;
                  end
               end
            end
         end
         lrgd_pkg::ST_GRAD_RUN: begin
            if (pass_st.done) begin
               div_start    = 1'b1;
               div_dividend = gw[lrgd_pkg::ACC_W-1] ? -gw : gw;
               neg_in       = gw[lrgd_pkg::ACC_W-1];
               state_in     = lrgd_pkg::ST_DIV_W;
            end
         end
         lrgd_pkg::ST_DIV_W: begin
            if (div_done) begin
               avg_w_in     = lrgd_pkg::sat32(quot_signed);
               div_start    = 1'b1;
               div_dividend = gb[lrgd_pkg::ACC_W-1] ? -gb : gb;
               neg_in       = gb[lrgd_pkg::ACC_W-1];
               state_in     = lrgd_pkg::ST_DIV_B;
            end
         end
         lrgd_pkg::ST_DIV_B: begin
            if (div_done) begin
               avg_b_in = lrgd_pkg::sat32(quot_signed);
               state_in = lrgd_pkg::ST_UPD_MUL;
            end
         end
         lrgd_pkg::ST_UPD_MUL: begin
            state_in = lrgd_pkg::ST_UPD_APPLY;
         end
         lrgd_pkg::ST_UPD_APPLY: begin
            weight_in  = lrgd_pkg::sat32(w_next);
            bias_in    = lrgd_pkg::sat32(b_next);
            epoch_in   = epoch_ff + 1'b1;
            pass_start = 1'b1;
            if (epoch_in == epoch_count_ff) begin
               final_in = 1'b1;
               state_in = lrgd_pkg::ST_COST_RUN;
            end else begin
               pass_mode = lrgd_pkg::PASS_GRAD;
               state_in  = lrgd_pkg::ST_GRAD_RUN;
            end
         end
         lrgd_pkg::ST_DONE: begin
            // result transaction goes out this cycle; store empties for next set
            count_in    = '0;
            overflow_in = 1'b0;
            state_in    = lrgd_pkg::ST_IDLE;
         end
         default: begin
            state_in = lrgd_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= lrgd_pkg::ST_IDLE;
         count_ff    <= '0;
         overflow_ff <= 1'b0;
         final_ff    <= 1'b0;
         epoch_ff    <= '0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         overflow_ff <= overflow_in;
         final_ff    <= final_in;
         epoch_ff    <= epoch_in;
      end
      neg_ff     <= neg_in;
      weight_ff  <= weight_in;
      bias_ff    <= bias_in;
      avg_w_ff   <= avg_w_in;
      avg_b_ff   <= avg_b_in;
      cost0_ff   <= cost0_in;
      cost1_ff   <= cost1_in;
      dropped_ff <= dropped_in;
      // learning rate times average gradient, unsigned Q0.16 by signed Q16.16
      prod_w_ff  <= lrgd_pkg::PROD_W'($signed({1'b0, learn_rate_ff}))
                    * lrgd_pkg::PROD_W'(avg_w_ff);
      prod_b_ff  <= lrgd_pkg::PROD_W'($signed({1'b0, learn_rate_ff}))
                    * lrgd_pkg::PROD_W'(avg_b_ff);
   end

   // --------------------------------------------------------------- outputs
   assign busy                     = (state_ff != lrgd_pkg::ST_IDLE);
   assign rsp_valid                = (state_ff == lrgd_pkg::ST_DONE);
   assign rsp_data.trained_weight  = weight_ff;
   assign rsp_data.trained_bias    = bias_ff;
   assign rsp_data.initial_cost    = cost0_ff;
   assign rsp_data.final_cost      = cost1_ff;
   assign rsp_data.samples_dropped = dropped_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= lrgd_pkg::COUNT_W'(lrgd_pkg::MAX_SAMPLES))
      else $error("sample count beyond store capacity");

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid && !busy)
      else $error("result strobe longer than one cycle");

   a_store_emptied: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> (count_ff == '0) && !overflow_ff)
      else $error("store not emptied after result transaction");

   a_div_in_run: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == lrgd_pkg::ST_COST_DIV || state_ff == lrgd_pkg::ST_DIV_W
                    || state_ff == lrgd_pkg::ST_DIV_B))
      else $error("divider finished outside a divide step");
`endif

endmodule

// File: rtl/lrgd_ram.sv
// ----------------------------------------------------------------------------
// lrgd_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module lrgd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/lrgd_div.sv
// ----------------------------------------------------------------------------
// lrgd_div
// Restoring divider, 64-bit dividend by sample count, one bit per cycle.
// ----------------------------------------------------------------------------
module lrgd_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [lrgd_pkg::ACC_W-1:0]  dividend,
   input  logic [lrgd_pkg::COUNT_W-1:0] divisor,
   output logic                        done,
   output logic [lrgd_pkg::ACC_W-1:0]  quotient
);

   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;
   logic [lrgd_pkg::DIV_CNT_W-1:0] step_ff, step_in;
   logic [lrgd_pkg::ACC_W-1:0]     dvd_ff, dvd_in;
   logic [lrgd_pkg::COUNT_W-1:0]   rem_ff, rem_in;
   logic [lrgd_pkg::COUNT_W-1:0]   dsr_ff, dsr_in;
   logic [lrgd_pkg::COUNT_W:0]     trial;
   logic                           qbit;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      trial   = {rem_ff, dvd_ff[lrgd_pkg::ACC_W-1]};
      qbit    = (trial >= {1'b0, dsr_ff});
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         dvd_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         rem_in = qbit ? lrgd_pkg::COUNT_W'(trial - {1'b0, dsr_ff})
                       : trial[lrgd_pkg::COUNT_W-1:0];
         dvd_in = {dvd_ff[lrgd_pkg::ACC_W-2:0], qbit};
         step_in = step_ff + 1'b1;
         if (step_ff == lrgd_pkg::DIV_CNT_W'(lrgd_pkg::ACC_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = dvd_ff;

endmodule

// File: rtl/lrgd_pass.sv
// ----------------------------------------------------------------------------
// lrgd_pass
// One sweep over the sample store: address issue, residual and product
// pipeline, and the cost or gradient accumulators.
// ----------------------------------------------------------------------------
module lrgd_pass (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  lrgd_pkg::pass_mode_type              mode,
   input  logic [lrgd_pkg::COUNT_W-1:0]         count,
   input  logic signed [lrgd_pkg::DATA_W-1:0]   weight,
   input  logic signed [lrgd_pkg::DATA_W-1:0]   bias,
   input  logic signed [lrgd_pkg::DATA_W-1:0]   rd_x,
   input  logic signed [lrgd_pkg::DATA_W-1:0]   rd_y,
   output logic                                 rd_en,
   output logic [lrgd_pkg::ADDR_W-1:0]          rd_addr,
   output lrgd_pkg::pass_status_type            status
);

   logic                            running_ff, running_in;
   logic                            issuing_ff, issuing_in;
   logic [lrgd_pkg::COUNT_W-1:0]    issue_ff, issue_in;
   lrgd_pkg::pass_mode_type         mode_ff, mode_in;
   logic                            v1_ff, v2_ff, v3_ff, v4_ff;
   logic                            done_ff, done_in;
   logic signed [lrgd_pkg::ACC_W-1:0]  p2_ff;
   logic signed [lrgd_pkg::DATA_W-1:0] x2_ff, y2_ff, x3_ff, d3_ff, d4_ff;
   logic signed [lrgd_pkg::ACC_W-1:0]  m4_ff;
   logic signed [lrgd_pkg::ACC_W-1:0]  resid;
   logic [lrgd_pkg::ACC_W-1:0]         err_ff, err_in;
   logic signed [lrgd_pkg::ACC_W-1:0]  gw_ff, gw_in, gb_ff, gb_in;

   always_comb begin
      running_in = running_ff;
      issuing_in = issuing_ff;
      issue_in   = issue_ff;
      mode_in    = mode_ff;
      done_in    = 1'b0;
      err_in     = err_ff;
      gw_in      = gw_ff;
      gb_in      = gb_ff;
      if (start) begin
         running_in = 1'b1;
         issuing_in = (count != '0);
         issue_in   = '0;
         mode_in    = mode;
         err_in     = '0;
         gw_in      = '0;
         gb_in      = '0;
      end else begin
         if (issuing_ff) begin
            issue_in = issue_ff + 1'b1;
            if (issue_in == count) begin
               issuing_in = 1'b0;
            end
         end
         if (v4_ff) begin
            err_in = err_ff + (m4_ff >> lrgd_pkg::Q_FRAC);
            gw_in  = gw_ff + (m4_ff >>> lrgd_pkg::Q_FRAC);
            gb_in  = gb_ff + lrgd_pkg::ACC_W'(d4_ff);
         end
         if (running_ff && !issuing_ff && !v1_ff && !v2_ff && !v3_ff && !v4_ff) begin
            running_in = 1'b0;
            done_in    = 1'b1;
         end
      end
   end

   // residual d = sat(floor(x*w) + b - y)
   assign resid = (p2_ff >>> lrgd_pkg::Q_FRAC) + lrgd_pkg::ACC_W'(bias)
                  - lrgd_pkg::ACC_W'(y2_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         issuing_ff <= 1'b0;
         issue_ff   <= '0;
         mode_ff    <= lrgd_pkg::PASS_COST;
         done_ff    <= 1'b0;
         v1_ff      <= 1'b0;
         v2_ff      <= 1'b0;
         v3_ff      <= 1'b0;
         v4_ff      <= 1'b0;
         err_ff     <= '0;
         gw_ff      <= '0;
         gb_ff      <= '0;
      end else begin
         running_ff <= running_in;
         issuing_ff <= issuing_in;
         issue_ff   <= issue_in;
         mode_ff    <= mode_in;
         done_ff    <= done_in;
         v1_ff      <= issuing_ff && !start;
         v2_ff      <= v1_ff;
         v3_ff      <= v2_ff;
         v4_ff      <= v3_ff;
         err_ff     <= err_in;
         gw_ff      <= gw_in;
         gb_ff      <= gb_in;
      end
      p2_ff <= lrgd_pkg::ACC_W'(rd_x) * lrgd_pkg::ACC_W'(weight);
      x2_ff <= rd_x;
      y2_ff <= rd_y;
      d3_ff <= lrgd_pkg::sat32(resid);
      x3_ff <= x2_ff;
      m4_ff <= lrgd_pkg::ACC_W'(d3_ff)
               * lrgd_pkg::ACC_W'((mode_ff == lrgd_pkg::PASS_COST) ? d3_ff : x3_ff);
      d4_ff <= d3_ff;
   end

   assign rd_en             = issuing_ff && !start;
   assign rd_addr           = issue_ff[lrgd_pkg::ADDR_W-1:0];
   assign status.done       = done_ff;
   assign status.err_sum    = err_ff;
   assign status.grad_w_sum = gw_ff;
   assign status.grad_b_sum = gb_ff;

endmodule
